[sv/wavhp_pkg.sv]
// Shared types and constants for the WAV header parser.
package wavhp_pkg;

    // Parse phases
    typedef enum logic [2:0] {
        PH_RIFF  = 3'd0,
        PH_RSIZE = 3'd1,
        PH_WAVE  = 3'd2,
        PH_HEAD  = 3'd3,
        PH_FMT   = 3'd4,
        PH_SKIP  = 3'd5,
        PH_WAIT  = 3'd6
    } phase_t;

    // Result status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_RIFF  = 3'd1;
    localparam logic [2:0] ST_BAD_WAVE  = 3'd2;
    localparam logic [2:0] ST_TRUNCATED = 3'd3;
    localparam logic [2:0] ST_FMT_SHORT = 3'd4;

    // Tags as they sit in a little-endian shift register: first byte lowest
    localparam logic [31:0] TAG_RIFF = 32'h4646_4952; // "RIFF"
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157; // "WAVE"
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66; // "fmt "
    localparam logic [31:0] TAG_DATA = 32'h6174_6164; // "data"

    localparam logic [31:0] FMT_BYTES = 32'd16;

    // One queued word
    typedef struct packed {
        logic [7:0] stream_byte;
        logic       is_last;
    } qword_t;

endpackage

[sv/wavhp_if.sv]
// Valid/ready channel interfaces for the byte input and the parse result.
interface wavhp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] stream_byte;
    logic       is_last;

    modport source (output valid, output stream_byte, output is_last, input ready);
    modport sink   (input valid, input stream_byte, input is_last, output ready);
endinterface

interface wavhp_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic        fmt_seen;
    logic [15:0] format_tag;
    logic [15:0] channel_count;
    logic [31:0] sample_rate;
    logic [31:0] byte_rate;
    logic [15:0] block_align;
    logic [15:0] bits_per_sample;
    logic [31:0] data_size;

    modport source (
        output valid, output status, output fmt_seen, output format_tag,
        output channel_count, output sample_rate, output byte_rate,
        output block_align, output bits_per_sample, output data_size,
        input ready
    );
    modport sink (
        input valid, input status, input fmt_seen, input format_tag,
        input channel_count, input sample_rate, input byte_rate,
        input block_align, input bits_per_sample, input data_size,
        output ready
    );
endinterface

[sv/wavhp_fifo.sv]
// Front end: accepts input words into a short queue ahead of the parser.
module wavhp_fifo #(
    parameter int DEPTH = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    wavhp_byte_if.sink          bytes,
    output logic                q_valid,
    output wavhp_pkg::qword_t   q_word,
    input  logic                q_pop
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    wavhp_pkg::qword_t mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          push;
    logic          pop;

    assign bytes.ready = (count_reg != FULL_CNT);
    assign push        = bytes.valid && bytes.ready;
    assign q_valid     = (count_reg != '0);
    assign pop         = q_pop && q_valid;
    assign q_word      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + CW'(1);
            2'b01:   count_next = count_reg - CW'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= '{stream_byte: bytes.stream_byte, is_last: bytes.is_last};
        end
    end

endmodule

[sv/wavhp_parser.sv]
// Back end: RIFF/WAVE parse state machine and registered result.
module wavhp_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  wavhp_pkg::qword_t   q_word,
    output logic                q_pop,
    wavhp_result_if.source      results
);

    wavhp_pkg::phase_t phase_reg, phase_next;
    logic [4:0]        idx_reg, idx_next;
    logic [31:0]       tag_reg, tag_next;
    logic [31:0]       size_reg, size_next;
    logic [31:0]       skip_reg, skip_next;
    logic [15:0][7:0]  fmt_reg, fmt_next;
    logic              fmt_flag_reg, fmt_flag_next;

    logic              out_valid_reg, out_valid_next;
    logic [2:0]        status_reg;
    logic              fmt_seen_reg;
    logic [15:0]       format_tag_reg;
    logic [15:0]       channel_count_reg;
    logic [31:0]       sample_rate_reg;
    logic [31:0]       byte_rate_reg;
    logic [15:0]       block_align_reg;
    logic [15:0]       bits_per_sample_reg;
    logic [31:0]       data_size_reg;

    logic              have_status;
    logic [2:0]        status_code;
    logic              produce;
    logic              do_restart;
    logic [7:0]        b;
    logic              last;

    assign b     = q_word.stream_byte;
    assign last  = q_word.is_last;
    // Take a word only when the result register can take whatever it causes
    assign q_pop = q_valid && (!out_valid_reg || results.ready);

    always_comb
    begin
        phase_next    = phase_reg;
        idx_next      = idx_reg;
        tag_next      = tag_reg;
        size_next     = size_reg;
        skip_next     = skip_reg;
        fmt_next      = fmt_reg;
        fmt_flag_next = fmt_flag_reg;
        have_status   = 1'b0;
        status_code   = wavhp_pkg::ST_OK;
        produce       = 1'b0;
        do_restart    = 1'b0;

        if (q_pop)
        begin
            case (phase_reg)
                wavhp_pkg::PH_WAIT:
                begin
                    // drop words up to the last one of the stream
                    do_restart = last;
                end
                wavhp_pkg::PH_RIFF, wavhp_pkg::PH_WAVE:
                begin
                    tag_next = {b, tag_reg[31:8]};
                    idx_next = idx_reg + 5'd1;
                    if (idx_reg == 5'd3)
                    begin
                        idx_next = '0;
                        if (phase_reg == wavhp_pkg::PH_RIFF)
                        begin
                            if (tag_next != wavhp_pkg::TAG_RIFF)
                            begin
                                have_status = 1'b1;
                                status_code = wavhp_pkg::ST_BAD_RIFF;
                            end
                            else
                            begin
                                phase_next = wavhp_pkg::PH_RSIZE;
                            end
                        end
                        else
                        begin
                            if (tag_next != wavhp_pkg::TAG_WAVE)
                            begin
                                have_status = 1'b1;
                                status_code = wavhp_pkg::ST_BAD_WAVE;
                            end
                            else
                            begin
                                phase_next = wavhp_pkg::PH_HEAD;
                            end
                        end
                    end
                end
                wavhp_pkg::PH_RSIZE:
                begin
                    size_next = {b, size_reg[31:8]};
                    idx_next  = idx_reg + 5'd1;
                    if (idx_reg == 5'd3)
                    begin
                        idx_next   = '0;
                        phase_next = wavhp_pkg::PH_WAVE;
                    end
                end
                wavhp_pkg::PH_HEAD:
                begin
                    if (idx_reg < 5'd4)
                    begin
                        tag_next = {b, tag_reg[31:8]};
                    end
                    else
                    begin
                        size_next = {b, size_reg[31:8]};
                    end
                    idx_next = idx_reg + 5'd1;
                    if (idx_reg == 5'd7)
                    begin
                        idx_next = '0;
                        if (tag_next == wavhp_pkg::TAG_DATA)
                        begin
                            have_status = 1'b1;
                            status_code = wavhp_pkg::ST_OK;
                        end
                        else if (tag_next == wavhp_pkg::TAG_FMT)
                        begin
                            if (size_next < wavhp_pkg::FMT_BYTES)
                            begin
                                have_status = 1'b1;
                                status_code = wavhp_pkg::ST_FMT_SHORT;
                            end
                            else
                            begin
                                skip_next  = size_next - wavhp_pkg::FMT_BYTES;
                                phase_next = wavhp_pkg::PH_FMT;
                            end
                        end
                        else
                        begin
                            skip_next  = size_next;
                            phase_next = (size_next != '0) ? wavhp_pkg::PH_SKIP
                                                           : wavhp_pkg::PH_HEAD;
                        end
                    end
                end
                wavhp_pkg::PH_FMT:
                begin
                    fmt_next[idx_reg[3:0]] = b;
                    idx_next = idx_reg + 5'd1;
                    if (idx_reg == 5'd15)
                    begin
                        idx_next      = '0;
                        fmt_flag_next = 1'b1;
                        phase_next    = (skip_reg != '0) ? wavhp_pkg::PH_SKIP
                                                         : wavhp_pkg::PH_HEAD;
                    end
                end
                wavhp_pkg::PH_SKIP:
                begin
                    if (skip_reg != '0)
                    begin
                        skip_next = skip_reg - 32'd1;
                    end
                    if (skip_next == '0)
                    begin
                        phase_next = wavhp_pkg::PH_HEAD;
                    end
                end
                default:
                begin
                    do_restart = 1'b1;
                end
            endcase

            if (phase_reg != wavhp_pkg::PH_WAIT)
            begin
                if (!have_status && last)
                begin
                    have_status = 1'b1;
                    status_code = wavhp_pkg::ST_TRUNCATED;
                end
                if (have_status)
                begin
                    produce = 1'b1;
                    if (last)
                    begin
                        do_restart = 1'b1;
                    end
                    else
                    begin
                        phase_next = wavhp_pkg::PH_WAIT;
                    end
                end
            end

            if (do_restart)
            begin
                phase_next    = wavhp_pkg::PH_RIFF;
                idx_next      = '0;
                tag_next      = '0;
                size_next     = '0;
                skip_next     = '0;
                fmt_next      = '0;
                fmt_flag_next = 1'b0;
            end
        end

        if (produce)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= wavhp_pkg::PH_RIFF;
            idx_reg       <= '0;
            tag_reg       <= '0;
            size_reg      <= '0;
            skip_reg      <= '0;
            fmt_reg       <= '0;
            fmt_flag_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            idx_reg       <= idx_next;
            tag_reg       <= tag_next;
            size_reg      <= size_next;
            skip_reg      <= skip_next;
            fmt_reg       <= fmt_next;
            fmt_flag_reg  <= fmt_flag_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload; a failure carries the status alone
    always_ff @(posedge clk)
    begin
        if (produce)
        begin
            status_reg <= status_code;
            if (status_code == wavhp_pkg::ST_OK)
            begin
                fmt_seen_reg        <= fmt_flag_reg;
                format_tag_reg      <= {fmt_reg[1], fmt_reg[0]};
                channel_count_reg   <= {fmt_reg[3], fmt_reg[2]};
                sample_rate_reg     <= {fmt_reg[7], fmt_reg[6], fmt_reg[5], fmt_reg[4]};
                byte_rate_reg       <= {fmt_reg[11], fmt_reg[10], fmt_reg[9], fmt_reg[8]};
                block_align_reg     <= {fmt_reg[13], fmt_reg[12]};
                bits_per_sample_reg <= {fmt_reg[15], fmt_reg[14]};
                // ok only ever comes on the final size byte of a data header
                data_size_reg       <= {b, size_reg[31:8]};
            end
            else
            begin
                fmt_seen_reg        <= 1'b0;
                format_tag_reg      <= '0;
                channel_count_reg   <= '0;
                sample_rate_reg     <= '0;
                byte_rate_reg       <= '0;
                block_align_reg     <= '0;
                bits_per_sample_reg <= '0;
                data_size_reg       <= '0;
            end
        end
    end

    assign results.valid           = out_valid_reg;
    assign results.status          = status_reg;
    assign results.fmt_seen        = fmt_seen_reg;
    assign results.format_tag      = format_tag_reg;
    assign results.channel_count   = channel_count_reg;
    assign results.sample_rate     = sample_rate_reg;
    assign results.byte_rate       = byte_rate_reg;
    assign results.block_align     = block_align_reg;
    assign results.bits_per_sample = bits_per_sample_reg;
    assign results.data_size       = data_size_reg;

endmodule

[sv/wav_header_parser_core.sv]
// WAV header parser top level: input queue feeding the parse engine.
// Takes a WAV file one byte word per cycle on "bytes", with is_last on the final word,
// and gives one result word on "results" per stream: status ok with the fmt fields and
// the data chunk size, or a failure code (bad RIFF tag, bad WAVE tag, truncated, fmt
// too short). Sustained rate is one byte per cycle while results are taken; the
// parse engine updates its state once per byte, and registers a result as it pops
// the byte that causes it. A DEPTH-entry queue keeps up to DEPTH further words
// accepted while a result waits to be taken. After a result, bytes up to the one
// marked last are consumed silently, and parsing restarts on the following byte.
module wav_header_parser_core #(
    parameter int DEPTH = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    wavhp_byte_if.sink      bytes,
    wavhp_result_if.source  results
);

    logic              q_valid;
    logic              q_pop;
    wavhp_pkg::qword_t q_word;

    wavhp_fifo #(
        .DEPTH (DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .bytes   (bytes),
        .q_valid (q_valid),
        .q_word  (q_word),
        .q_pop   (q_pop)
    );

    wavhp_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_word  (q_word),
        .q_pop   (q_pop),
        .results (results)
    );

endmodule

[test/tb.sv]
// Self-checking testbench for the WAV header parser core.
`timescale 1ns / 1ps

module tb;

    localparam int unsigned CYCLE_LIMIT = 500000;
    localparam int unsigned BYTE_GOAL = 1300;
    localparam int unsigned STREAM_GOAL = 20;
    localparam int unsigned CALM_FROM = 1100;
    localparam int unsigned DRAIN_CYCLES = 20;
    localparam logic [31:0] TAG_LIST = 32'h5453_494C; // "LIST"
    localparam logic [31:0] TAG_JUNK = 32'h6B6E_756A; // "junk"

    typedef struct packed {
        logic [2:0]  status;
        logic        fmt_seen;
        logic [15:0] format_tag;
        logic [15:0] channel_count;
        logic [31:0] sample_rate;
        logic [31:0] byte_rate;
        logic [15:0] block_align;
        logic [15:0] bits_per_sample;
        logic [31:0] data_size;
    } wav_info_t;

    logic clk = 1'b0;
    logic rst_n;

    wavhp_byte_if bytes_if ();
    wavhp_result_if results_if ();

    wav_header_parser_core DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .bytes   (bytes_if),
        .results (results_if)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Parser model state
    wavhp_pkg::phase_t ps_phase;
    int unsigned ps_index;
    logic [31:0] ps_tag;
    logic [31:0] ps_size;
    logic [31:0] ps_skip;
    logic [7:0]  ps_fmt [16];
    logic        ps_fmt_done;

    wav_info_t   pending_info [$];
    logic [7:0]  wav_bytes [$];
    int unsigned bytes_sent = 0;
    int unsigned errors = 0;
    int unsigned cycles = 0;
    bit          idle_on = 1'b0;

    function automatic void clear_parser();
        ps_phase = wavhp_pkg::PH_RIFF;
        ps_index = 0;
        ps_tag = '0;
        ps_size = '0;
        ps_skip = '0;
        foreach (ps_fmt[i]) ps_fmt[i] = '0;
        ps_fmt_done = 1'b0;
    endfunction

    // Advance the parser by one accepted byte and queue any result it gives
    function automatic void parse_byte(input logic [7:0] b, input logic last);
        wav_info_t  info;
        bit         fire;
        logic [2:0] st;
        fire = 1'b0;
        st = wavhp_pkg::ST_OK;
        if (ps_phase == wavhp_pkg::PH_WAIT)
        begin
            if (last)
                clear_parser();
            return;
        end
        case (ps_phase)
            wavhp_pkg::PH_RIFF, wavhp_pkg::PH_WAVE:
            begin
                ps_tag = {b, ps_tag[31:8]};
                ps_index++;
                if (ps_index == 4)
                begin
                    ps_index = 0;
                    if (ps_phase == wavhp_pkg::PH_RIFF)
                    begin
                        if (ps_tag != wavhp_pkg::TAG_RIFF)
                        begin
                            fire = 1'b1;
                            st = wavhp_pkg::ST_BAD_RIFF;
                        end
                        else
                            ps_phase = wavhp_pkg::PH_RSIZE;
                    end
                    else if (ps_tag != wavhp_pkg::TAG_WAVE)
                    begin
                        fire = 1'b1;
                        st = wavhp_pkg::ST_BAD_WAVE;
                    end
                    else
                        ps_phase = wavhp_pkg::PH_HEAD;
                end
            end
            wavhp_pkg::PH_RSIZE:
            begin
                ps_size = {b, ps_size[31:8]};
                ps_index++;
                if (ps_index == 4)
                begin
                    ps_index = 0;
                    ps_phase = wavhp_pkg::PH_WAVE;
                end
            end
            wavhp_pkg::PH_HEAD:
            begin
                if (ps_index < 4)
                    ps_tag = {b, ps_tag[31:8]};
                else
                    ps_size = {b, ps_size[31:8]};
                ps_index++;
                if (ps_index == 8)
                begin
                    ps_index = 0;
                    if (ps_tag == wavhp_pkg::TAG_DATA)
                        fire = 1'b1;
                    else if (ps_tag == wavhp_pkg::TAG_FMT)
                    begin
                        if (ps_size < wavhp_pkg::FMT_BYTES)
                        begin
                            fire = 1'b1;
                            st = wavhp_pkg::ST_FMT_SHORT;
                        end
                        else
                        begin
                            ps_skip = ps_size - wavhp_pkg::FMT_BYTES;
                            ps_phase = wavhp_pkg::PH_FMT;
                        end
                    end
                    else
                    begin
                        ps_skip = ps_size;
                        ps_phase = (ps_skip != 0) ? wavhp_pkg::PH_SKIP : wavhp_pkg::PH_HEAD;
                    end
                end
            end
            wavhp_pkg::PH_FMT:
            begin
                ps_fmt[4'(ps_index)] = b;
                ps_index++;
                if (ps_index == 16)
                begin
                    ps_index = 0;
                    ps_fmt_done = 1'b1;
                    ps_phase = (ps_skip != 0) ? wavhp_pkg::PH_SKIP : wavhp_pkg::PH_HEAD;
                end
            end
            wavhp_pkg::PH_SKIP:
            begin
                if (ps_skip != 0)
                    ps_skip--;
                if (ps_skip == 0)
                    ps_phase = wavhp_pkg::PH_HEAD;
            end
            default: ;
        endcase
        if (!fire && last)
        begin
            fire = 1'b1;
            st = wavhp_pkg::ST_TRUNCATED;
        end
        if (fire)
        begin
            info = '0;
            info.status = st;
            if (st == wavhp_pkg::ST_OK)
            begin
                info.fmt_seen = ps_fmt_done;
                info.format_tag = {ps_fmt[1], ps_fmt[0]};
                info.channel_count = {ps_fmt[3], ps_fmt[2]};
                info.sample_rate = {ps_fmt[7], ps_fmt[6], ps_fmt[5], ps_fmt[4]};
                info.byte_rate = {ps_fmt[11], ps_fmt[10], ps_fmt[9], ps_fmt[8]};
                info.block_align = {ps_fmt[13], ps_fmt[12]};
                info.bits_per_sample = {ps_fmt[15], ps_fmt[14]};
                info.data_size = ps_size;
            end
            pending_info.push_back(info);
            if (last)
                clear_parser();
            else
                ps_phase = wavhp_pkg::PH_WAIT;
        end
    endfunction

    // Present one word and hold it until taken; valid stays high between words unless an idle gap is inserted
    task automatic send_byte(input logic [7:0] b, input logic last);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            bytes_if.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        bytes_if.valid <= 1'b1;
        bytes_if.stream_byte <= b;
        bytes_if.is_last <= last;
        do
            @(posedge clk);
        while (!bytes_if.ready);
        bytes_sent++;
        parse_byte(b, last);
    endtask

    task automatic send_stream();
        for (int i = 0; i < wav_bytes.size(); i++)
            send_byte(wav_bytes[i], i == wav_bytes.size() - 1);
        wav_bytes = {};
    endtask

    function automatic void put_u32(input logic [31:0] v);
        for (int k = 0; k < 4; k++)
            wav_bytes.push_back(v[8*k +: 8]);
    endfunction

    function automatic void put_rand(input int unsigned n);
        repeat (n) wav_bytes.push_back(8'($urandom_range(0, 255)));
    endfunction

    function automatic void put_fill(input int unsigned n, input logic [7:0] v);
        repeat (n) wav_bytes.push_back(v);
    endfunction

    function automatic void put_preamble();
        put_u32(wavhp_pkg::TAG_RIFF);
        put_u32($urandom());
        put_u32(wavhp_pkg::TAG_WAVE);
    endfunction

    function automatic void cut_to(input int unsigned n);
        while (wav_bytes.size() > n)
            wav_bytes.delete(wav_bytes.size() - 1);
    endfunction

    // Well-formed header: random chunk walk ending in a data header and up to three data bytes
    function automatic void build_wav();
        int unsigned extra;
        int unsigned sel;
        put_preamble();
        repeat ($urandom_range(0, 3))
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                sel = $urandom_range(0, 7);
                extra = (sel < 5) ? 0 : $urandom_range(1, 6);
                put_u32(wavhp_pkg::TAG_FMT);
                put_u32(wavhp_pkg::FMT_BYTES + extra);
                if (sel == 0)
                    put_fill(16 + extra, 8'hFF);
                else
                    put_rand(16 + extra);
            end
            else
            begin
                extra = $urandom_range(0, 6);
                put_u32($urandom());
                put_u32(extra);
                put_rand(extra);
            end
        end
        put_u32(wavhp_pkg::TAG_DATA);
        sel = $urandom_range(0, 5);
        put_u32(sel == 0 ? 32'h0 : sel == 1 ? 32'hFFFF_FFFF : $urandom());
        put_rand($urandom_range(0, 3));
    endfunction

    task automatic test_bad_tags();
        // bad RIFF with words to drop after it
        put_u32(wavhp_pkg::TAG_RIFF ^ 32'h0800_0000);
        put_u32(32'h5AA5_5AA5);
        send_stream();
        // bad WAVE on the final word
        put_u32(wavhp_pkg::TAG_RIFF);
        put_u32(32'h0);
        put_u32(wavhp_pkg::TAG_WAVE ^ 32'h8000_0000);
        send_stream();
        // single word stream
        wav_bytes.push_back(8'h52);
        send_stream();
    endtask

    task automatic test_no_fmt();
        put_u32(wavhp_pkg::TAG_RIFF);
        put_u32(32'hFFFF_FFFF);
        put_u32(wavhp_pkg::TAG_WAVE);
        put_u32(wavhp_pkg::TAG_DATA);
        put_u32(32'hFFFF_FFFF);
        send_stream();
    endtask

    task automatic test_fmt_fields();
        put_preamble();
        put_u32(wavhp_pkg::TAG_FMT);
        put_u32(wavhp_pkg::FMT_BYTES);
        put_fill(16, 8'hFF);
        put_u32(wavhp_pkg::TAG_DATA);
        put_u32(32'h0);
        send_stream();
        put_preamble();
        put_u32(wavhp_pkg::TAG_FMT);
        put_u32(wavhp_pkg::FMT_BYTES);
        put_fill(16, 8'h00);
        put_u32(wavhp_pkg::TAG_DATA);
        put_u32(32'h1234_5678);
        put_rand(3);
        send_stream();
    endtask

    task automatic test_fmt_short();
        put_preamble();
        put_u32(wavhp_pkg::TAG_FMT);
        put_u32(32'd15);
        put_rand(2);
        send_stream();
        // short size ends on the final word: short wins over truncation
        put_preamble();
        put_u32(wavhp_pkg::TAG_FMT);
        put_u32(32'd0);
        send_stream();
    endtask

    task automatic test_chunk_walk();
        put_preamble();
        put_u32(wavhp_pkg::TAG_FMT);
        put_u32(32'd20);
        put_rand(20);
        put_u32(TAG_LIST);
        put_u32(32'd0);
        put_u32(TAG_JUNK);
        put_u32(32'd3);
        put_rand(3);
        put_u32(wavhp_pkg::TAG_FMT);
        put_u32(wavhp_pkg::FMT_BYTES);
        put_rand(16);
        put_u32(wavhp_pkg::TAG_DATA);
        put_u32($urandom());
        put_rand(1);
        send_stream();
    endtask

    task automatic test_truncation();
        put_u32(wavhp_pkg::TAG_RIFF);
        cut_to(3);
        send_stream();
        put_u32(wavhp_pkg::TAG_RIFF);
        put_u32($urandom());
        cut_to(6);
        send_stream();
        put_preamble();
        put_u32(wavhp_pkg::TAG_FMT);
        put_u32(wavhp_pkg::FMT_BYTES);
        put_rand(5);
        send_stream();
        put_preamble();
        put_u32(TAG_JUNK);
        put_u32(32'hFFFF_FFF0);
        put_rand(4);
        send_stream();
    endtask

    task automatic test_random_streams();
        int unsigned mode;
        int unsigned n;
        int unsigned streams;
        streams = 0;
        while (bytes_sent < BYTE_GOAL || streams < STREAM_GOAL)
        begin
            idle_on = (bytes_sent < CALM_FROM) && ($urandom_range(0, 3) != 0);
            mode = $urandom_range(0, 19);
            if (mode < 13)
                build_wav();
            else if (mode < 15)
            begin
                build_wav();
                n = $urandom_range(0, wav_bytes.size() - 1);
                wav_bytes[n] = wav_bytes[n] ^ (8'h01 << $urandom_range(0, 7));
            end
            else if (mode < 17)
            begin
                build_wav();
                cut_to($urandom_range(1, wav_bytes.size() - 1));
            end
            else if (mode < 18)
            begin
                put_preamble();
                put_u32(wavhp_pkg::TAG_FMT);
                put_u32($urandom_range(0, 15));
                put_rand($urandom_range(0, 2));
            end
            else
            begin
                // noise, sometimes opening with part or all of a RIFF tag
                if ($urandom_range(0, 1) == 0)
                begin
                    put_u32(wavhp_pkg::TAG_RIFF);
                    cut_to($urandom_range(1, 4));
                end
                put_rand($urandom_range(1, 12));
            end
            send_stream();
            streams++;
        end
        idle_on = 1'b0;
    endtask

    // Result side: random stall bursts while idling is on
    initial
    begin
        results_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (idle_on && $urandom_range(0, 2) == 0)
            begin
                results_if.ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
            results_if.ready <= 1'b1;
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        wav_info_t want;
        if (rst_n && results_if.valid && results_if.ready)
        begin
            if (pending_info.size() == 0)
            begin
                $error("result word with none expected: status %0d", results_if.status);
                errors++;
            end
            else
            begin
                want = pending_info.pop_front();
                check_field("status", 32'(want.status), 32'(results_if.status));
                check_field("fmt_seen", 32'(want.fmt_seen), 32'(results_if.fmt_seen));
                check_field("format_tag", 32'(want.format_tag),
                            32'(results_if.format_tag));
                check_field("channel_count", 32'(want.channel_count),
                            32'(results_if.channel_count));
                check_field("sample_rate", want.sample_rate, results_if.sample_rate);
                check_field("byte_rate", want.byte_rate, results_if.byte_rate);
                check_field("block_align", 32'(want.block_align),
                            32'(results_if.block_align));
                check_field("bits_per_sample", 32'(want.bits_per_sample),
                            32'(results_if.bits_per_sample));
                check_field("data_size", want.data_size, results_if.data_size);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb NOT OK");
            $finish;
        end
    end

    initial
    begin
        rst_n <= 1'b0;
        bytes_if.valid <= 1'b0;
        bytes_if.stream_byte <= '0;
        bytes_if.is_last <= 1'b0;
        clear_parser();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_bad_tags();
        test_no_fmt();
        test_fmt_fields();
        test_fmt_short();
        test_chunk_walk();
        test_truncation();
        test_random_streams();
        bytes_if.valid <= 1'b0;
        while (pending_info.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

[filelist.f]
sv/wavhp_pkg.sv
sv/wavhp_if.sv
sv/wavhp_fifo.sv
sv/wavhp_parser.sv
sv/wav_header_parser_core.sv
test/tb.sv
